### sv/buddy_block_allocator_defines.svh
// Assertion macros shared by the buddy allocator RTL.
// Included by the top level; depends on nothing else.
`ifndef BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define BBA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define BBA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### sv/bba_pkg.sv
// Types and constants of the buddy block allocator.
// No dependencies.
package bba_pkg;
  localparam int unsigned LOG2_MAX = 10;
  localparam logic [1:0] NODE_ABSENT = 2'd0;
  localparam logic [1:0] NODE_FREE   = 2'd1;
  localparam logic [1:0] NODE_OWNED  = 2'd2;
  localparam logic [1:0] NODE_SPLIT  = 2'd3;
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOSPACE = 3'd1;
  localparam logic [2:0] ST_UNKNOWN = 3'd2;
  localparam logic [2:0] ST_ZERO    = 3'd3;
  localparam logic [2:0] ST_BUSY    = 3'd4;
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [5:0] process_id;
    logic [10:0] request_size;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  block_start;
    logic [10:0] block_size;
    logic [10:0] free_bytes;
  } rsp_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_SCAN, S_SCANCHK, S_SPLIT, S_SPLITR,
    S_FREERD, S_MREAD, S_MCHK, S_MCLR, S_MFIN, S_OUT
  } state_t;
endpackage

### sv/bba_if.sv
// Valid/ready channel carrying one payload item.
// Depends on nothing; payload type is a parameter.
interface bba_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### sv/bba_node_mem.sv
// Node status memory of the buddy tree, registered read.
// Depends on nothing.
module bba_node_mem #(
  parameter int unsigned DEPTH = 2047,
  parameter int unsigned AW = 11
) (
  input  logic          clk,
  input  logic [AW-1:0] raddr,
  output logic [1:0]    rdata,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [1:0]    wdata
);
  logic [1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### sv/bba_owner_mem.sv
// Owner table memory: start and level per process, registered read.
// Depends on nothing.
module bba_owner_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW = 6
) (
  input  logic          clk,
  input  logic [AW-1:0] raddr,
  output logic [13:0]   rdata,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [13:0]   wdata
);
  logic [13:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### sv/buddy_block_allocator.sv
// Buddy allocator over a tree of node states held in a block memory with a
// registered read; owner start and level sit in a second such memory. One
// item is taken at a time, only in the idle state, and its result is held
// until taken; the next item can be accepted in the cycle after that. An
// error item passes through decode before its result is offered. An allocate
// scans levels from the target size upward, reading then checking each node,
// then splits level by level (node split, right half free) and marks the
// block owned. A free reads the owner entry after decode, then per merged
// level reads, checks and clears the buddy pair; a buddy check that finds it
// not free stops merging below the root, and a final write frees the block.
// After reset and after each register write a clearing pass sweeps all
// 2*MEMORY_SIZE-1 nodes of the node memory before items are taken.
module buddy_block_allocator #(
  parameter int unsigned MEMORY_SIZE = 1024,
  parameter int unsigned MAX_PROCESSES = 64
) (
  input  logic        clk,
  input  logic        rst,
  bba_if.sink         in_ch,
  bba_if.source       out_ch,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata
);
  import bba_pkg::*;
  `include "buddy_block_allocator_defines.svh"

  localparam int unsigned NODES = 2 * MEMORY_SIZE - 1;
  localparam int unsigned NAW = $clog2(NODES + 1);
  localparam int unsigned NP = (MAX_PROCESSES > 64) ? 64 : MAX_PROCESSES;
  localparam int unsigned PAW = $clog2(NP);
  localparam int unsigned ML = $clog2(MEMORY_SIZE + 1) - 1;

  state_t state, state_next;
  logic [3:0]  m;
  logic [10:0] free_count;
  logic [NP-1:0] owner_valid;
  req_t        rq;
  rsp_t        rsp;
  logic [NAW-1:0] idx, clr_idx;
  logic [NAW-1:0] scan_end;
  logic [3:0]  lv, target;
  logic [9:0]  ostart;

  logic [NAW-1:0] n_raddr, n_waddr;
  logic [1:0] n_rdata, n_wdata;
  logic n_we;
  logic [13:0] o_rdata;
  logic o_we;
  logic [PAW-1:0] pid_idx;
  logic [9:0]  start_w;

  assign pid_idx = rq.process_id[PAW-1:0];

  bba_node_mem #(.DEPTH(NODES), .AW(NAW)) u_node (
    .clk(clk), .raddr(n_raddr), .rdata(n_rdata),
    .we(n_we), .waddr(n_waddr), .wdata(n_wdata)
  );
  bba_owner_mem #(.DEPTH(NP), .AW(PAW)) u_owner (
    .clk(clk), .raddr(pid_idx), .rdata(o_rdata),
    .we(o_we), .waddr(pid_idx), .wdata({start_w, lv})
  );

  logic [3:0] cfg_m;
  always_comb begin
    cfg_m = cfg_wdata;
    if (cfg_m < 4'd1) cfg_m = 4'd1;
    if (cfg_m > 4'(ML)) cfg_m = 4'(ML);
  end

  // ceil log2 of request
  logic [3:0] lg_calc;
  always_comb begin
    lg_calc = 4'd11;
    for (int i = 10; i >= 0; i--) begin
      if ((12'd1 << i) >= {1'b0, rq.request_size}) lg_calc = 4'(i);
    end
  end

  logic pid_ok, own_v;
  assign pid_ok = (32'(rq.process_id) < NP);
  assign own_v = pid_ok ? owner_valid[pid_idx] : 1'b0;

  logic [2:0] dec_status;
  always_comb begin
    if (!pid_ok) dec_status = ST_UNKNOWN;
    else if (rq.mode == MODE_FREE) dec_status = own_v ? ST_OK : ST_UNKNOWN;
    else if (rq.request_size == '0) dec_status = ST_ZERO;
    else if (own_v) dec_status = ST_BUSY;
    else if (lg_calc > m) dec_status = ST_NOSPACE;
    else dec_status = ST_OK;
  end

  logic [NAW-1:0] sib, parent, lvl_first, child_r;
  assign sib = idx[0] ? idx + 1'b1 : idx - 1'b1;
  assign parent = (idx - 1'b1) >> 1;
  assign lvl_first = NAW'((12'd1 << lv) - 12'd1);
  assign child_r = {idx[NAW-2:0], 1'b0} + NAW'(2);

  logic [10:0] size_w;
  assign size_w = 11'd1 << (m - lv);
  logic [11:0] off_w;
  assign off_w = 12'(idx - lvl_first) << (m - lv);
  assign start_w = off_w[9:0];

  logic [10:0] fc_sub, fc_add;
  logic [11:0] fc_sum, fc_cap;
  assign fc_sub = (free_count >= size_w) ? free_count - size_w : '0;
  assign fc_sum = {1'b0, free_count} + {1'b0, size_w};
  assign fc_cap = 12'd1 << m;
  assign fc_add = (fc_sum > fc_cap) ? fc_cap[10:0] : fc_sum[10:0];

  // owner entry of a free: clamp level, locate its node
  logic [3:0] f_level;
  logic [NAW-1:0] f_idx;
  assign f_level = (o_rdata[3:0] > m) ? m : o_rdata[3:0];
  assign f_idx = NAW'(((12'd1 << f_level) - 12'd1) +
                      ({2'b00, o_rdata[13:4]} >> (m - f_level)));

  assign in_ch.ready = (state == S_IDLE) && !cfg_we;
  assign out_ch.valid = (state == S_OUT);
  assign out_ch.data = rsp;

  always_comb begin
    state_next = state;
    n_raddr = idx;
    n_we = 1'b0;
    n_waddr = idx;
    n_wdata = NODE_ABSENT;
    o_we = 1'b0;
    case (state)
      S_CLEAR: begin
        n_we = 1'b1;
        n_waddr = clr_idx;
        n_wdata = (clr_idx == '0) ? NODE_FREE : NODE_ABSENT;
        if (32'(clr_idx) == NODES - 1) state_next = S_IDLE;
      end
      S_IDLE: if (in_ch.valid && in_ch.ready) state_next = S_DECODE;
      S_DECODE: begin
        if (dec_status != ST_OK) state_next = S_OUT;
        else if (rq.mode == MODE_FREE) state_next = S_FREERD;
        else state_next = S_SCAN;
      end
      S_SCAN: state_next = S_SCANCHK;
      S_SCANCHK: begin
        if (n_rdata == NODE_FREE) state_next = S_SPLIT;
        else if (idx == scan_end && lv == 4'd0) state_next = S_OUT;
        else state_next = S_SCAN;
      end
      S_SPLIT: begin
        n_we = 1'b1;
        if (lv == target) begin
          n_wdata = NODE_OWNED;
          o_we = 1'b1;
          state_next = S_OUT;
        end else begin
          n_wdata = NODE_SPLIT;
          state_next = S_SPLITR;
        end
      end
      S_SPLITR: begin
        // right half becomes free; left half is handled on the next level
        n_we = 1'b1;
        n_waddr = child_r;
        n_wdata = NODE_FREE;
        state_next = S_SPLIT;
      end
      S_FREERD: state_next = (f_level == 4'd0) ? S_MFIN : S_MREAD;
      S_MREAD: begin
        n_raddr = sib;
        state_next = S_MCHK;
      end
      S_MCHK: begin
        if (n_rdata == NODE_FREE) begin
          n_we = 1'b1;
          n_waddr = sib;
          n_wdata = NODE_ABSENT;
          state_next = S_MCLR;
        end else begin
          state_next = S_MFIN;
        end
      end
      S_MCLR: begin
        n_we = 1'b1;
        n_wdata = NODE_ABSENT;
        state_next = (parent == '0) ? S_MFIN : S_MREAD;
      end
      S_MFIN: begin
        n_we = 1'b1;
        n_wdata = NODE_FREE;
        state_next = S_OUT;
      end
      S_OUT: if (out_ch.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
    if (cfg_we) state_next = S_CLEAR;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m <= 4'(ML);
      free_count <= 11'(1 << ML);
      owner_valid <= '0;
      clr_idx <= '0;
    end else if (cfg_we) begin
      m <= cfg_m;
      free_count <= 11'd1 << cfg_m;
      owner_valid <= '0;
      clr_idx <= '0;
    end else begin
      case (state)
        S_CLEAR: clr_idx <= clr_idx + 1'b1;
        S_IDLE: if (in_ch.valid) rq <= in_ch.data;
        S_DECODE: begin
          rsp.status <= dec_status;
          rsp.free_bytes <= free_count;
          rsp.block_start <= '0;
          rsp.block_size <= '0;
          target <= m - lg_calc;
          lv <= m - lg_calc;
          idx <= NAW'((12'd1 << (m - lg_calc)) - 12'd1);
          scan_end <= NAW'((12'd2 << (m - lg_calc)) - 12'd2);
        end
        S_SCANCHK: begin
          if (n_rdata != NODE_FREE) begin
            if (idx != scan_end) begin
              idx <= idx + 1'b1;
            end else if (lv == 4'd0) begin
              rsp.status <= ST_NOSPACE;
            end else begin
              lv <= lv - 1'b1;
              idx <= lvl_first >> 1;
              scan_end <= lvl_first - 1'b1;
            end
          end
        end
        S_SPLIT: begin
          if (lv == target) begin
            rsp.block_start <= start_w;
            rsp.block_size <= size_w;
            rsp.free_bytes <= fc_sub;
            free_count <= fc_sub;
            owner_valid[pid_idx] <= 1'b1;
          end
        end
        S_SPLITR: begin
          idx <= {idx[NAW-2:0], 1'b1};
          lv <= lv + 1'b1;
        end
        S_FREERD: begin
          lv <= f_level;
          ostart <= o_rdata[13:4];
          idx <= f_idx;
        end
        S_MCLR: idx <= parent;
        S_MFIN: begin
          owner_valid[pid_idx] <= 1'b0;
          free_count <= fc_add;
          rsp.block_start <= ostart;
          rsp.block_size <= size_w;
          rsp.free_bytes <= fc_add;
        end
        default: ;
      endcase
    end
  end

  `BBA_ASSERT_NEXT(a_out_hold, out_ch.valid && !out_ch.ready && !cfg_we, out_ch.valid && $stable(out_ch.data))
  `BBA_ASSERT_IMP(a_ready_idle, in_ch.ready, state == S_IDLE)
  `BBA_ASSERT_IMP(a_free_cap, 1'b1, free_count <= (11'd1 << m))
endmodule

### verif/buddy_block_allocator_tb.sv
// Self-checking testbench for the buddy block allocator: random and directed
// allocate/free items checked against an in-bench tree predictor.
// Depends on bba_pkg, bba_if and buddy_block_allocator.
module buddy_block_allocator_tb;
  import bba_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [3:0] cfg_wdata = 4'd0;

  always #5 clk = ~clk;

  bba_if #(.payload_t(req_t)) in_ch (clk);
  bba_if #(.payload_t(rsp_t)) out_ch (clk);

  buddy_block_allocator dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // Predictor state
  logic [1:0] tree_node[2047];
  bit         pid_held[64];
  int         pid_start[64];
  int         pid_level[64];
  int         free_cnt;
  int         size_log2;

  req_t pending_q[$];
  rsp_t owed_rsp_q[$];
  int   mismatches = 0;
  bit   in_fire = 1'b0;
  bit   out_fire = 1'b0;
  bit   gaps_on = 1'b1;
  int   send_gap = 0;
  int   stall_gap = 0;
  bit   live_pid[64];

  function automatic void tree_clear();
    for (int i = 0; i < 2047; i++) tree_node[i] = NODE_ABSENT;
    for (int p = 0; p < 64; p++) pid_held[p] = 1'b0;
    tree_node[0] = NODE_FREE;
    free_cnt = 1 << size_log2;
  endfunction

  function automatic rsp_t allocator_predict(req_t r);
    rsp_t o;
    int lg, target, found, flevel, idx, level, sz, st, sib, parent;
    int pid;
    o = '0;
    pid = r.process_id;
    st = 0;
    sz = 0;
    o.status = ST_OK;
    if (r.mode == MODE_ALLOC) begin
      if (r.request_size == 0) begin
        o.status = ST_ZERO;
      end else if (pid_held[pid]) begin
        o.status = ST_BUSY;
      end else begin
        lg = 0;
        while (lg < 11 && (1 << lg) < r.request_size) lg++;
        if (lg > size_log2) begin
          o.status = ST_NOSPACE;
        end else begin
          target = size_log2 - lg;
          found = -1;
          flevel = 0;
          for (int lv = target; lv >= 0 && found < 0; lv--) begin
            for (int k = 0; k < (1 << lv); k++) begin
              if (tree_node[(1 << lv) - 1 + k] == NODE_FREE) begin
                found = (1 << lv) - 1 + k;
                flevel = lv;
                break;
              end
            end
          end
          if (found < 0) begin
            o.status = ST_NOSPACE;
          end else begin
            idx = found;
            level = flevel;
            while (level < target && 2 * idx + 2 < 2047) begin
              tree_node[idx] = NODE_SPLIT;
              tree_node[2 * idx + 1] = NODE_FREE;
              tree_node[2 * idx + 2] = NODE_FREE;
              idx = 2 * idx + 1;
              level++;
            end
            tree_node[idx] = NODE_OWNED;
            sz = 1 << (size_log2 - level);
            st = (idx - ((1 << level) - 1)) << (size_log2 - level);
            pid_held[pid] = 1'b1;
            pid_start[pid] = st;
            pid_level[pid] = level;
            free_cnt = (free_cnt >= sz) ? free_cnt - sz : 0;
          end
        end
      end
    end else begin
      if (!pid_held[pid]) begin
        o.status = ST_UNKNOWN;
      end else begin
        level = pid_level[pid];
        if (level > size_log2) level = size_log2;
        st = pid_start[pid];
        sz = 1 << (size_log2 - level);
        idx = ((1 << level) - 1) + (st >> (size_log2 - level));
        pid_held[pid] = 1'b0;
        tree_node[idx] = NODE_FREE;
        // merge free buddies upward
        while (idx > 0) begin
          sib = (idx & 1) ? idx + 1 : idx - 1;
          parent = (idx - 1) >> 1;
          if (tree_node[sib] != NODE_FREE) break;
          tree_node[idx] = NODE_ABSENT;
          tree_node[sib] = NODE_ABSENT;
          tree_node[parent] = NODE_FREE;
          idx = parent;
        end
        free_cnt += sz;
        if (free_cnt > (1 << size_log2)) free_cnt = 1 << size_log2;
      end
    end
    if (o.status == ST_OK) begin
      o.block_start = st[9:0];
      o.block_size = sz[10:0];
    end
    o.free_bytes = free_cnt[10:0];
    return o;
  endfunction

  // Checker and predictor, sampled at the rising edge
  always @(posedge clk) begin
    rsp_t want;
    in_fire <= in_ch.valid && in_ch.ready;
    out_fire <= out_ch.valid && out_ch.ready;
    if (rst) begin
      size_log2 = LOG2_MAX;
      tree_clear();
    end else begin
      if (cfg_we) begin
        size_log2 = (cfg_wdata < 1) ? 1 : (cfg_wdata > LOG2_MAX) ? LOG2_MAX : cfg_wdata;
        tree_clear();
      end
      if (out_ch.valid && out_ch.ready) begin
        if (owed_rsp_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_ch.data);
        end else begin
          want = owed_rsp_q.pop_front();
          if (want !== out_ch.data) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p actual %p", want, out_ch.data);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) owed_rsp_q.push_back(allocator_predict(in_ch.data));
    end
  end

  // Request driver, changes at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_fire) begin
      // hold until taken
    end else if (send_gap > 0) begin
      send_gap <= send_gap - 1;
      in_ch.valid <= 1'b0;
    end else if (pending_q.size() > 0) begin
      in_ch.data <= pending_q.pop_front();
      in_ch.valid <= 1'b1;
      send_gap <= gaps_on ? $urandom_range(0, 3) : 0;
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // Result sink with random stalls
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (stall_gap > 0) begin
      stall_gap <= stall_gap - 1;
      out_ch.ready <= 1'b0;
    end else if (out_fire) begin
      out_ch.ready <= 1'b1;
      stall_gap <= gaps_on ? $urandom_range(0, 3) : 0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic push_item(logic mode, int pid, int sz);
    req_t r;
    r.mode = mode;
    r.process_id = pid[5:0];
    r.request_size = sz[10:0];
    pending_q.push_back(r);
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pending_q.size() != 0 || in_ch.valid || owed_rsp_q.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_size_log2(int v);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = v[3:0];
    @(negedge clk);
    cfg_we = 1'b0;
    for (int p = 0; p < 64; p++) live_pid[p] = 1'b0;
  endtask

  task automatic random_items(int n, int m);
    int r, pid, tries;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      pid = $urandom_range(0, 63);
      if (r < 10) begin
        push_item(1'($urandom_range(0, 1)), pid, $urandom_range(0, 2047));
      end else if (r < 55) begin
        push_item(MODE_ALLOC, pid, $urandom_range(1, 1 << $urandom_range(0, m)));
        live_pid[pid] = 1'b1;
      end else begin
        tries = 0;
        while (!live_pid[pid] && tries < 64) begin
          pid = (pid + 1) % 64;
          tries++;
        end
        push_item(MODE_FREE, pid, $urandom_range(0, 2047));
        live_pid[pid] = 1'b0;
      end
    end
  endtask

  initial begin
    int sizes[8] = '{1, 0, 15, 4, 2, 7, 10, 3};
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: field extremes and every status at full size
    push_item(MODE_ALLOC, 0, 0);
    push_item(MODE_ALLOC, 63, 1);
    push_item(MODE_ALLOC, 63, 5);
    push_item(MODE_ALLOC, 1, 2047);
    push_item(MODE_ALLOC, 1, 1024);
    push_item(MODE_ALLOC, 2, 3);
    push_item(MODE_ALLOC, 3, 512);
    push_item(MODE_ALLOC, 4, 256);
    push_item(MODE_ALLOC, 5, 129);
    push_item(MODE_FREE, 42, 2047);
    push_item(MODE_FREE, 63, 0);
    push_item(MODE_FREE, 2, 0);
    push_item(MODE_FREE, 4, 0);
    push_item(MODE_FREE, 3, 0);
    push_item(MODE_FREE, 5, 0);
    push_item(MODE_ALLOC, 6, 1024);
    push_item(MODE_ALLOC, 7, 1);
    push_item(MODE_FREE, 6, 0);
    push_item(MODE_ALLOC, 21, 682);
    push_item(MODE_FREE, 21, 1365);
    random_items(150, LOG2_MAX);
    drain();

    foreach (sizes[i]) begin
      gaps_on = (i % 3) != 2;
      write_size_log2(sizes[i]);
      random_items(145, (sizes[i] < 1) ? 1 : (sizes[i] > 10) ? 10 : sizes[i]);
      drain();
    end

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #400_000_000;
    $display("Test completed with failures");
    $finish;
  end
endmodule
